// ===== sv/double_ended_queue_defines.svh =====
// Assertion macros shared by the double-ended queue RTL.
`ifndef DOUBLE_ENDED_QUEUE_DEFINES_SVH
`define DOUBLE_ENDED_QUEUE_DEFINES_SVH

// Checks that a condition implies a consequence in the same cycle.
`define DQ_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Checks that a condition implies a consequence in the following cycle.
`define DQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/dque_pkg.sv =====
`timescale 1ns / 1ps

package dque_pkg;

    // Storage geometry.
    localparam int DEPTH      = 16;
    localparam int DATA_WIDTH = 32;
    localparam int ADDR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int SUM_W      = CNT_W + 1;

    // Fixed port widths.
    localparam int IN_W     = 32;
    localparam int OUT_W    = 32;
    localparam int MODE_W   = 2;
    localparam int STATUS_W = 2;
    localparam int OCC_W    = 5;

    // Operation codes.
    localparam logic [MODE_W-1:0] MODE_PUSH_FRONT = 2'd0;
    localparam logic [MODE_W-1:0] MODE_PUSH_BACK  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_POP_FRONT  = 2'd2;
    localparam logic [MODE_W-1:0] MODE_POP_BACK   = 2'd3;

    // Status codes.
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

endpackage

// ===== sv/dque_ram.sv =====
`timescale 1ns / 1ps

module dque_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 32
) (
    input  logic                                     clk,
    input  logic                                     wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                         wr_data,
    input  logic                                     rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== sv/double_ended_queue.sv =====
`timescale 1ns / 1ps
// Bounded double-ended queue of dque_pkg::DEPTH words held in a ring memory. An item is
// taken when start is high and busy is low; busy stays low, so an item may be given
// in every cycle. Each item yields exactly one result in the cycle after it was taken,
// shown for that single cycle with done high; the receiver cannot stall it and must
// take it then. The result is delayed by the registered read port of the memory.
// A pop on an empty queue reports empty and a push on a full queue reports full;
// neither changes the contents. data_out is zero unless a pop succeeded.

`include "double_ended_queue_defines.svh"

module double_ended_queue (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [dque_pkg::MODE_W-1:0]   mode,
    input  logic [dque_pkg::IN_W-1:0]     data_in,
    output logic                          done,
    output logic [dque_pkg::OUT_W-1:0]    data_out,
    output logic [dque_pkg::STATUS_W-1:0] status,
    output logic [dque_pkg::OCC_W-1:0]    occupancy
);

    localparam int AW = dque_pkg::ADDR_W;
    localparam int CW = dque_pkg::CNT_W;
    localparam int SW = dque_pkg::SUM_W;

    logic [AW-1:0] front_reg, front_next;
    logic [CW-1:0] count_reg, count_next;
    logic          done_reg;
    logic          pop_ok_reg, pop_ok_next;
    logic [dque_pkg::STATUS_W-1:0] status_reg, status_next;
    logic [CW-1:0] occ_reg;

    logic          accept;
    logic          full;
    logic          empty;
    logic [AW-1:0] front_dec;
    logic [AW-1:0] front_inc;
    logic [SW-1:0] back_sum;
    logic [SW-1:0] last_sum;
    logic [AW-1:0] back_slot;
    logic [AW-1:0] last_slot;

    logic                            wr_en;
    logic [AW-1:0]                   wr_addr;
    logic                            rd_en;
    logic [AW-1:0]                   rd_addr;
    logic [dque_pkg::DATA_WIDTH-1:0] rd_data;

    // The queue never stalls the sender.
    assign busy   = 1'b0;
    assign accept = start && !busy;

    assign full  = (count_reg == CW'(dque_pkg::DEPTH));
    assign empty = (count_reg == '0);

    // Ring index arithmetic, modulo the depth.
    always_comb
    begin
        front_dec = (front_reg == '0) ? AW'(dque_pkg::DEPTH - 1) : front_reg - 1'b1;
        front_inc = (front_reg == AW'(dque_pkg::DEPTH - 1)) ? '0 : front_reg + 1'b1;

        back_sum = SW'(front_reg) + SW'(count_reg);
        if (back_sum >= SW'(dque_pkg::DEPTH))
        begin
            back_sum = back_sum - SW'(dque_pkg::DEPTH);
        end
        back_slot = back_sum[AW-1:0];

        last_sum = SW'(front_reg) + SW'(count_reg) + SW'(dque_pkg::DEPTH - 1);
        if (last_sum >= SW'(2 * dque_pkg::DEPTH))
        begin
            last_sum = last_sum - SW'(2 * dque_pkg::DEPTH);
        end
        else if (last_sum >= SW'(dque_pkg::DEPTH))
        begin
            last_sum = last_sum - SW'(dque_pkg::DEPTH);
        end
        last_slot = last_sum[AW-1:0];
    end

    // Operation decode: index update and memory access for the accepted item.
    always_comb
    begin
        front_next  = front_reg;
        count_next  = count_reg;
        status_next = dque_pkg::ST_OK;
        pop_ok_next = 1'b0;
        wr_en       = 1'b0;
        wr_addr     = back_slot;
        rd_en       = 1'b0;
        rd_addr     = front_reg;

        if (accept)
        begin
            unique case (mode)
                dque_pkg::MODE_PUSH_FRONT:
                begin
                    if (full)
                    begin
                        status_next = dque_pkg::ST_FULL;
                    end
                    else
                    begin
                        front_next = front_dec;
                        wr_en      = 1'b1;
                        wr_addr    = front_dec;
                        count_next = count_reg + 1'b1;
                    end
                end
                dque_pkg::MODE_PUSH_BACK:
                begin
                    if (full)
                    begin
                        status_next = dque_pkg::ST_FULL;
                    end
                    else
                    begin
                        wr_en      = 1'b1;
                        wr_addr    = back_slot;
                        count_next = count_reg + 1'b1;
                    end
                end
                dque_pkg::MODE_POP_FRONT:
                begin
                    if (empty)
                    begin
                        status_next = dque_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        rd_en       = 1'b1;
                        rd_addr     = front_reg;
                        pop_ok_next = 1'b1;
                        front_next  = front_inc;
                        count_next  = count_reg - 1'b1;
                    end
                end
                dque_pkg::MODE_POP_BACK:
                begin
                    if (empty)
                    begin
                        status_next = dque_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        rd_en       = 1'b1;
                        rd_addr     = last_slot;
                        pop_ok_next = 1'b1;
                        count_next  = count_reg - 1'b1;
                    end
                end
                default:
                begin
                    status_next = dque_pkg::ST_OK;
                end
            endcase
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg <= '0;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            front_reg <= front_next;
            count_reg <= count_next;
            done_reg  <= accept;
        end
    end

    // Result fields, aligned with the memory read data.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pop_ok_reg <= pop_ok_next;
            status_reg <= status_next;
            occ_reg    <= count_next;
        end
    end

    // Ring memory holding the words.
    dque_ram #(
        .DEPTH (dque_pkg::DEPTH),
        .WIDTH (dque_pkg::DATA_WIDTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (data_in[dque_pkg::DATA_WIDTH-1:0]),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign done      = done_reg;
    assign data_out  = pop_ok_reg ? dque_pkg::OUT_W'(rd_data) : '0;
    assign status    = status_reg;
    assign occupancy = dque_pkg::OCC_W'(occ_reg);

    // Checks on the index and result logic.
    `DQ_ASSERT_SAME(a_count_bound, 1'b1, count_reg <= CW'(dque_pkg::DEPTH), "count above depth")
    `DQ_ASSERT_NEXT(a_result_follows, accept, done, "accepted item gave no result")
    `DQ_ASSERT_SAME(a_full_status, done && (status == dque_pkg::ST_FULL), occupancy == dque_pkg::OCC_W'(dque_pkg::DEPTH), "full reported below depth")
    `DQ_ASSERT_SAME(a_empty_status, done && (status == dque_pkg::ST_EMPTY), (occupancy == '0) && (data_out == '0), "empty reported with words held")

endmodule

// ===== tb/tb_double_ended_queue.sv =====
`timescale 1ns / 1ps

module tb_double_ended_queue;
    import dque_pkg::*;

    // One result as it appears on the output ports.
    typedef struct packed {
        logic [OUT_W-1:0]    data;
        logic [STATUS_W-1:0] status;
        logic [OCC_W-1:0]    occ;
    } deque_result_t;

    // Mirrors the ring store and predicts the result of every accepted item.
    class deque_scoreboard;
        logic [DATA_WIDTH-1:0] ring_words [DEPTH];
        int unsigned           front_slot;
        int unsigned           word_total;
        deque_result_t         expected_results [$];
        int                    failures;

        function new();
            front_slot = 0;
            word_total = 0;
            failures   = 0;
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        // Applies one operation to the mirrored deque and queues its result.
        function void note_item(logic [MODE_W-1:0] op, logic [IN_W-1:0] word);
            deque_result_t res;
            int unsigned   slot;
            res.data   = '0;
            res.status = ST_OK;
            case (op)
                MODE_PUSH_FRONT, MODE_PUSH_BACK:
                begin
                    if (word_total >= DEPTH)
                    begin
                        res.status = ST_FULL;
                    end
                    else
                    begin
                        if (op == MODE_PUSH_FRONT)
                        begin
                            front_slot = (front_slot + DEPTH - 1) % DEPTH;
                            slot = front_slot;
                        end
                        else
                        begin
                            slot = (front_slot + word_total) % DEPTH;
                        end
                        ring_words[slot] = word[DATA_WIDTH-1:0];
                        word_total++;
                    end
                end
                default:
                begin
                    if (word_total == 0)
                    begin
                        res.status = ST_EMPTY;
                    end
                    else
                    begin
                        if (op == MODE_POP_FRONT)
                        begin
                            slot = front_slot;
                            front_slot = (front_slot + 1) % DEPTH;
                        end
                        else
                        begin
                            slot = (front_slot + word_total - 1) % DEPTH;
                        end
                        res.data = OUT_W'(ring_words[slot]);
                        word_total--;
                    end
                end
            endcase
            res.occ = word_total[OCC_W-1:0];
            expected_results.push_back(res);
        endfunction

        // Compares one result from the block with the oldest prediction.
        function void check_result(logic [OUT_W-1:0] data, logic [STATUS_W-1:0] status,
                                   logic [OCC_W-1:0] occ);
            deque_result_t want;
            if (expected_results.size() == 0)
            begin
                failures++;
                if (failures <= 10)
                    $display("ERROR: result with nothing expected: data %h status %0d occ %0d",
                             data, status, occ);
            end
            else
            begin
                want = expected_results.pop_front();
                if (data !== want.data || status !== want.status || occ !== want.occ)
                begin
                    failures++;
                    if (failures <= 10)
                        $display("ERROR: expected data %h status %0d occ %0d, got %h %0d %0d",
                                 want.data, want.status, want.occ, data, status, occ);
                end
            end
        endfunction
    endclass

    logic                clk;
    logic                rst_n;
    logic                start;
    logic                busy;
    logic [MODE_W-1:0]   mode;
    logic [IN_W-1:0]     data_in;
    logic                done;
    logic [OUT_W-1:0]    data_out;
    logic [STATUS_W-1:0] status;
    logic [OCC_W-1:0]    occupancy;

    deque_scoreboard deque_sb = new();
    bit              gaps_on;

    double_ended_queue i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .mode      (mode),
        .data_in   (data_in),
        .done      (done),
        .data_out  (data_out),
        .status    (status),
        .occupancy (occupancy)
    );

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Watches both handshakes at the rising edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
                deque_sb.check_result(data_out, status, occupancy);
            if (start && !busy)
                deque_sb.note_item(mode, data_in);
        end
    end

    // Offers one item and holds it until the block takes it.
    task automatic drive_item(logic [MODE_W-1:0] op, logic [IN_W-1:0] word);
        @(negedge clk);
        start   <= 1'b1;
        mode    <= op;
        data_in <= word;
        do
            @(posedge clk);
        while (busy);
    endtask

    // Leaves the start line low for a random stretch, mostly short.
    task automatic idle_gap();
        int unsigned pick;
        int unsigned cycles;
        pick   = $urandom_range(99);
        cycles = 0;
        if (gaps_on)
        begin
            if (pick >= 95)
                cycles = $urandom_range(40, 8);
            else if (pick >= 70)
                cycles = $urandom_range(3, 1);
        end
        if (cycles > 0)
        begin
            @(negedge clk);
            start <= 1'b0;
            repeat (cycles - 1) @(negedge clk);
        end
    endtask

    // Stops offering items until every outstanding result has come back.
    task automatic hold_until_drained(int unsigned limit, output bit drained);
        int unsigned waited;
        waited = 0;
        @(negedge clk);
        start <= 1'b0;
        while (deque_sb.pending() != 0 && waited < limit)
        begin
            @(posedge clk);
            waited++;
        end
        drained = (deque_sb.pending() == 0);
    endtask

    function automatic logic [MODE_W-1:0] pick_mode(int unsigned push_pct);
        if ($urandom_range(99) < push_pct)
            return $urandom_range(1) ? MODE_PUSH_BACK : MODE_PUSH_FRONT;
        return $urandom_range(1) ? MODE_POP_BACK : MODE_POP_FRONT;
    endfunction

    function automatic logic [IN_W-1:0] pick_word();
        int unsigned pick;
        pick = $urandom_range(7);
        if (pick == 0)
            return '0;
        if (pick == 1)
            return '1;
        return $urandom();
    endfunction

    // Timeout guard.
    initial
    begin
        #5000000;
        $display("Test completed with failures");
        $finish;
    end

    // Stimulus.
    initial
    begin
        int unsigned sent;
        int unsigned phase_left;
        int unsigned push_pct;
        bit          drained;
        bit          paused;

        rst_n   = 1'b0;
        start   = 1'b0;
        mode    = MODE_PUSH_FRONT;
        data_in = '0;
        gaps_on = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part: pops when empty, fill to full with extreme, patterned and
        // random words, pushes when full, then pops from both ends.
        drive_item(MODE_POP_FRONT, '0);
        drive_item(MODE_POP_BACK, '1);
        drive_item(MODE_PUSH_FRONT, '0);
        drive_item(MODE_PUSH_BACK, '1);
        drive_item(MODE_PUSH_FRONT, '1);
        drive_item(MODE_PUSH_BACK, '0);
        for (int i = 0; i < 12; i++)
            drive_item((i % 2) ? MODE_PUSH_FRONT : MODE_PUSH_BACK,
                       (i % 3 == 0) ? 32'hA5A5_A5A5 : (i % 3 == 1) ? 32'h5A5A_5A5A
                                                                  : $urandom());
        drive_item(MODE_PUSH_FRONT, 32'h1234_5678);
        drive_item(MODE_PUSH_BACK, 32'h8765_4321);
        drive_item(MODE_POP_FRONT, '0);
        drive_item(MODE_POP_BACK, '0);
        drive_item(MODE_POP_FRONT, '1);
        drive_item(MODE_POP_BACK, '1);

        // Random part in phases that lean towards filling, draining or neither.
        sent       = 0;
        phase_left = 0;
        push_pct   = 50;
        paused     = 1'b0;
        while (sent < 1450)
        begin
            if (phase_left == 0)
            begin
                phase_left = $urandom_range(60, 10);
                case ($urandom_range(2))
                    0:       push_pct = 80;
                    1:       push_pct = 20;
                    default: push_pct = 50;
                endcase
                gaps_on = ($urandom_range(3) != 0);
            end
            if (!paused && sent >= 700)
            begin
                hold_until_drained(1000, drained);
                paused = 1'b1;
            end
            drive_item(pick_mode(push_pct), pick_word());
            idle_gap();
            sent++;
            phase_left--;
        end

        // Wait for the last results, then keep watching for stray ones.
        hold_until_drained(1000, drained);
        repeat (5) @(posedge clk);
        if (drained && deque_sb.failures == 0 && deque_sb.pending() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
